### hw/rtl/cble_pkg.sv
// Shared types, constants and helpers for the CAN bus load estimator.
// No dependencies; every other file imports this package.
`default_nettype none

package cble_pkg;

    localparam int BUS_COUNT   = 4;
    localparam int BUS_W       = 2;
    localparam int IDX_W       = 3;
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 32;
    localparam int LOAD_W      = 8;
    localparam int RATE_W      = 20;
    localparam int BUDGET_W    = 18;
    localparam int ADD_W       = 11;
    localparam int PROD_W      = 39;
    localparam int QUO_W       = 8;
    localparam int REM_W       = BUDGET_W + QUO_W;
    localparam int STEP_W      = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int NUM_REGS    = 4;

    localparam int FRAME_BASE     = 41;
    localparam int BYTE_BITS      = 9;
    localparam int EXT_BITS       = 18;
    localparam int DEFAULT_BUDGET = 125000;
    localparam int RATE_RESET     = 500000;
    // sample = (count * 1000 / budget) / 10 == count * 100 / budget
    localparam int PCT_SCALE      = 1000 / 10;
    localparam int BLEND_OLD      = 3;

    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRAME_MOD,
        ST_TICK_RD,
        ST_TICK_MUL,
        ST_TICK_DIV,
        ST_TICK_WAIT,
        ST_TICK_BLEND
    } cble_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  bit_count;
        logic [LOAD_W-1:0] smoothed;
    } cble_entry_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [BUDGET_W-1:0] divisor;
    } cble_div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } cble_div_rsp_t;

    // Quarter-second bit budget; a rate below 4 falls back to the default.
    function automatic logic [BUDGET_W-1:0] cble_budget(input logic [RATE_W-1:0] rate);
        logic [BUDGET_W-1:0] q;
        q = rate[RATE_W-1:2];
        if (q == '0) begin
            q = BUDGET_W'(DEFAULT_BUDGET);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/cble_if.sv
// Channel interfaces: frame/tick requests, load reports, register writes.
// Depends on cble_pkg.
`default_nettype none

interface cble_req_if
    import cble_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] bus_index;
    logic [LEN_W-1:0] frame_length;
    logic             extended_id;

    modport source (output valid, req_type, bus_index, frame_length, extended_id,
                    input ready);
    modport sink   (input valid, req_type, bus_index, frame_length, extended_id,
                    output ready);
endinterface

interface cble_load_if
    import cble_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BUS_W-1:0]  load_bus;
    logic [LOAD_W-1:0] load_percent;
    logic              last_of_tick;

    modport source (output valid, load_bus, load_percent, last_of_tick, input ready);
    modport sink   (input valid, load_bus, load_percent, last_of_tick, output ready);
endinterface

interface cble_cfg_if
    import cble_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [RATE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/cble_mem.sv
// Per-bus state memory: bit counter and smoothed load, registered read.
// Depends on cble_pkg. Valid bits make unwritten entries read as zero.
`default_nettype none

module cble_mem
    import cble_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             we,
    input  wire logic [BUS_W-1:0] waddr,
    input  wire cble_entry_t      wdata,
    input  wire logic             re,
    input  wire logic [BUS_W-1:0] raddr,
    output cble_entry_t           rdata
);

    cble_entry_t          mem [BUS_COUNT];
    logic [BUS_COUNT-1:0] valid_reg;
    cble_entry_t          rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/cble_div.sv
// Iterative restoring divider for the load sample, saturating at 255.
// Depends on cble_pkg. One quotient bit per cycle after an overflow check.
`default_nettype none

module cble_div
    import cble_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cble_div_req_t req,
    output cble_div_rsp_t      rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [BUDGET_W-1:0] dvs_reg;

    logic [REM_W-1:0]    trial;
    logic [PROD_W-1:0]   limit;
    logic                saturate;

    assign trial    = {{QUO_W{1'b0}}, dvs_reg} << step_reg;
    assign limit    = {{(PROD_W-REM_W){1'b0}}, req.divisor, {QUO_W{1'b0}}};
    assign saturate = (req.dividend >= limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= !saturate;
                done_reg <= saturate;
                step_reg <= STEP_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvs_reg <= req.divisor;
            rem_reg <= req.dividend[REM_W-1:0];
            quo_reg <= saturate ? {QUO_W{1'b1}} : '0;
        end
        else if (busy_reg && rem_reg >= trial)
        begin
            rem_reg           <= rem_reg - trial;
            quo_reg[step_reg] <= 1'b1;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/can_bus_load_estimator.sv
// CAN bus load estimator, top level: control sequencer, rate registers, output register.
// Frame item: counter read at accept, written back on the next edge.
// Tick item, per bus: read, multiply, divider start, 8 divide steps and done, blend;
// a saturating sample skips the divide steps, and a held output stalls the blend.
// Most of a tick's time goes to the iterative divider. One item is in work at a time.
// Reset: rate registers to 500000, state memory valid bits cleared (reads as zero), no sweep.
`default_nettype none

module can_bus_load_estimator
    import cble_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cble_req_if.sink   req,
    cble_load_if.source load,
    cble_cfg_if.sink   cfg
);

    cble_state_t state_reg, state_next;

    // captured frame item
    logic [BUS_W-1:0] fbus_reg;
    logic [LEN_W-1:0] flen_reg;
    logic             fext_reg;

    // tick progress
    logic [BUS_W-1:0]  bus_reg, bus_next;
    logic [PROD_W-1:0] prod_reg;
    logic              nz_reg;
    logic [LOAD_W-1:0] old_reg;

    // output register
    logic              ovalid_reg;
    logic [BUS_W-1:0]  obus_reg;
    logic [LOAD_W-1:0] opct_reg;
    logic              olast_reg;
    logic              out_load;

    logic [RATE_W-1:0] rate_reg [NUM_REGS];

    // memory and divider hookups
    logic          mem_we, mem_re;
    logic [BUS_W-1:0] mem_waddr, mem_raddr;
    cble_entry_t   mem_wdata, mem_rdata;
    cble_div_req_t div_req;
    cble_div_rsp_t div_rsp;

    logic              accept;
    logic [ADD_W-1:0]  frame_bits;
    logic [CNT_W:0]    sum;
    logic [ADD_W-1:0]  blend_sum;
    logic [LOAD_W-1:0] blended;
    logic              last_bus;

    cble_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cble_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // frame bits: 41 + 9 per byte, +18 for an extended id; counter saturates
    assign frame_bits = ADD_W'(FRAME_BASE) + ADD_W'(flen_reg) * ADD_W'(BYTE_BITS)
                      + (fext_reg ? ADD_W'(EXT_BITS) : ADD_W'(0));
    assign sum = {1'b0, mem_rdata.bit_count} + {{(CNT_W+1-ADD_W){1'b0}}, frame_bits};

    // three parts old, one part new; traffic seen forces at least 1
    assign blend_sum = ADD_W'(old_reg) * ADD_W'(BLEND_OLD) + ADD_W'(div_rsp.quotient);
    always_comb
    begin
        blended = blend_sum[LOAD_W+1:2];
        if (blended == '0 && nz_reg)
        begin
            blended = LOAD_W'(1);
        end
    end

    assign last_bus = (bus_reg == BUS_W'(BUS_COUNT - 1));

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        bus_next         = bus_reg;
        mem_we           = 1'b0;
        mem_waddr        = fbus_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = bus_reg;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = cble_budget(rate_reg[bus_reg]);
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = req.bus_index[BUS_W-1:0];
                if (accept)
                begin
                    if (req.req_type == REQ_TICK)
                    begin
                        bus_next   = '0;
                        state_next = ST_TICK_RD;
                    end
                    else if (req.bus_index < IDX_W'(BUS_COUNT))
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_FRAME_MOD;
                    end
                end
            end
            ST_FRAME_MOD:
            begin
                mem_we              = 1'b1;
                mem_wdata.smoothed  = mem_rdata.smoothed;
                mem_wdata.bit_count = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
                state_next          = ST_IDLE;
            end
            ST_TICK_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_TICK_MUL;
            end
            ST_TICK_MUL:
            begin
                state_next = ST_TICK_DIV;
            end
            ST_TICK_DIV:
            begin
                div_req.start = 1'b1;
                state_next    = ST_TICK_WAIT;
            end
            ST_TICK_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_TICK_BLEND;
                end
            end
            ST_TICK_BLEND:
            begin
                // hold until the output register is free
                if (!ovalid_reg || load.ready)
                begin
                    out_load           = 1'b1;
                    mem_we             = 1'b1;
                    mem_waddr          = bus_reg;
                    mem_wdata.smoothed = blended;
                    if (last_bus)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bus_next   = bus_reg + 1'b1;
                        state_next = ST_TICK_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bus_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bus_reg   <= bus_next;
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (load.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fbus_reg <= req.bus_index[BUS_W-1:0];
            flen_reg <= req.frame_length;
            fext_reg <= req.extended_id;
        end
        if (state_reg == ST_TICK_MUL)
        begin
            prod_reg <= {{(PROD_W-CNT_W){1'b0}}, mem_rdata.bit_count} * PROD_W'(PCT_SCALE);
            nz_reg   <= (mem_rdata.bit_count != '0);
            old_reg  <= mem_rdata.smoothed;
        end
        if (out_load)
        begin
            obus_reg  <= bus_reg;
            opct_reg  <= blended;
            olast_reg <= last_bus;
        end
    end

    // rate registers; writes beyond the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rate_reg[i] <= RATE_W'(RATE_RESET);
            end
        end
        else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_REGS))
        begin
            rate_reg[cfg.index[BUS_W-1:0]] <= cfg.data;
        end
    end

    assign load.valid        = ovalid_reg;
    assign load.load_bus     = obus_reg;
    assign load.load_percent = opct_reg;
    assign load.last_of_tick = olast_reg;

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for can_bus_load_estimator: frame/tick items in, per-bus load reports out.
// Depends on cble_pkg and the channel interfaces in cble_if.sv; the load math is predicted here.
`default_nettype none

module tb_top
    import cble_pkg::*;
();

    // Frame bit estimate and load math constants
    localparam int FRAME_OVERHEAD   = 41;
    localparam int BYTE_COST        = 9;
    localparam int EXT_COST         = 18;
    localparam int FALLBACK_BUDGET  = 125000;
    localparam int PERMILLE         = 1000;
    localparam int PCT_CAP          = 255;

    // Rate register map: register i holds the nominal rate of bus i
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BUS0  = 0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BUS1  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BUS2  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BUS3  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_FIRST = NUM_REGS;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LAST  = '1;
    localparam logic [RATE_W-1:0]    RATE_FULL      = '1;
    localparam logic [IDX_W-1:0]     BUS_ABSENT_LO  = BUS_COUNT;
    localparam logic [IDX_W-1:0]     BUS_ABSENT_HI  = '1;
    localparam logic [LEN_W-1:0]     LEN_CAN_FD     = 64;
    localparam logic [LEN_W-1:0]     LEN_FULL       = '1;

    localparam int MAX_IDLE     = 14;
    localparam int QUIET_CYCLES = 12;   // frame write-back lands in the cycle after accept
    localparam int DRAIN_CYCLES = 60;   // about one full tick sweep
    localparam int HOLD_CYCLES  = 240;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 55;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] bus;
        logic [LEN_W-1:0] len;
        logic             ext;
    } bus_event_t;

    typedef struct packed {
        logic [BUS_W-1:0]  bus;
        logic [LOAD_W-1:0] pct;
        logic              last;
    } load_report_t;

    logic clk;
    logic rst_n;

    cble_req_if  req_ch ();
    cble_load_if load_ch ();
    cble_cfg_if  cfg_ch ();

    can_bus_load_estimator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .load  (load_ch),
        .cfg   (cfg_ch)
    );

    // Load predictor state: rate registers, per-bus bit counters, smoothed loads
    logic [RATE_W-1:0] rate_reg     [NUM_REGS];
    logic [CNT_W-1:0]  bits_seen    [BUS_COUNT];
    logic [LOAD_W-1:0] smoothed_pct [BUS_COUNT];
    load_report_t      pending_loads[$];

    // Idling controls for the sender and the receiver
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold;

    int faults;
    int frames_sent;
    int frames_absent;
    int ticks_sent;
    int reports_seen;
    int cfg_writes;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    task automatic load_model_reset();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            rate_reg[i] = RATE_RESET;
        end
        for (int b = 0; b < BUS_COUNT; b++)
        begin
            bits_seen[b]    = '0;
            smoothed_pct[b] = '0;
        end
    endtask

    // Frame: accumulate bits with saturation. Tick: one report per bus, in order.
    task automatic load_model_apply(input bus_event_t ev);
        logic [CNT_W-1:0] add;
        longint unsigned  budget;
        longint unsigned  sample;
        longint unsigned  blend;
        load_report_t     rep;
        if (ev.req_type == REQ_FRAME)
        begin
            frames_sent++;
            if (ev.bus < BUS_COUNT)
            begin
                add = FRAME_OVERHEAD + BYTE_COST * ev.len + (ev.ext ? EXT_COST : 0);
                if (bits_seen[ev.bus] > ('1 - add))
                    bits_seen[ev.bus] = '1;
                else
                    bits_seen[ev.bus] = bits_seen[ev.bus] + add;
            end
            else
            begin
                frames_absent++;
            end
        end
        else
        begin
            ticks_sent++;
            for (int b = 0; b < BUS_COUNT; b++)
            begin
                budget = rate_reg[b] >> 2;
                if (budget == 0)
                    budget = FALLBACK_BUDGET;
                sample = ((64'(bits_seen[b]) * PERMILLE) / budget) / 10;
                if (sample > PCT_CAP)
                    sample = PCT_CAP;
                blend = (64'(smoothed_pct[b]) * 3 + sample) / 4;
                // any traffic at all keeps the reported load off zero
                if (blend == 0 && bits_seen[b] != 0)
                    blend = 1;
                smoothed_pct[b] = LOAD_W'(blend);
                bits_seen[b]    = '0;
                rep.bus  = BUS_W'(b);
                rep.pct  = smoothed_pct[b];
                rep.last = (b == BUS_COUNT - 1);
                pending_loads.push_back(rep);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Item builders and drivers
    // ---------------------------------------------------------------------

    function automatic bus_event_t mk_frame(input logic [IDX_W-1:0] bus,
                                            input logic [LEN_W-1:0] len,
                                            input logic ext);
        bus_event_t ev;
        ev.req_type = REQ_FRAME;
        ev.bus      = bus;
        ev.len      = len;
        ev.ext      = ext;
        return ev;
    endfunction

    // Frame fields carry random junk on a tick; the block must ignore them
    function automatic bus_event_t mk_tick();
        bus_event_t ev;
        ev.req_type = REQ_TICK;
        ev.bus      = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        ev.len      = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
        ev.ext      = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    // Mostly in-range buses and classic/FD lengths; a few absent buses and oversize lengths
    function automatic bus_event_t rand_event(input int tick_pct);
        bus_event_t ev;
        logic [IDX_W-1:0] bus;
        logic [LEN_W-1:0] len;
        if ($urandom_range(0, 99) < tick_pct)
            return mk_tick();
        if ($urandom_range(0, 15) == 0)
            bus = IDX_W'($urandom_range(BUS_COUNT, (1 << IDX_W) - 1));
        else
            bus = IDX_W'($urandom_range(0, BUS_COUNT - 1));
        if ($urandom_range(0, 9) == 0)
            len = LEN_W'($urandom_range(LEN_CAN_FD + 1, LEN_FULL));
        else
            len = LEN_W'($urandom_range(0, LEN_CAN_FD));
        ev = mk_frame(bus, len, 1'($urandom_range(0, 1)));
        return ev;
    endfunction

    // Rate classes: fallback budget, unit budget, low, mid, nominal, beyond spec
    function automatic logic [RATE_W-1:0] rand_rate();
        case ($urandom_range(0, 5))
            0:       return RATE_W'($urandom_range(0, 3));
            1:       return RATE_W'($urandom_range(4, 7));
            2:       return RATE_W'($urandom_range(8, 4000));
            3:       return RATE_W'($urandom_range(4001, 60000));
            4:       return RATE_W'($urandom_range(60001, 1000000));
            default: return RATE_W'($urandom_range(1000001, RATE_FULL));
        endcase
    endfunction

    // One item on the request channel; valid stays up for back-to-back items
    task automatic send_event(input bus_event_t ev);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= ev.req_type;
        req_ch.bus_index    <= ev.bus;
        req_ch.frame_length <= ev.len;
        req_ch.extended_id  <= ev.ext;
        do @(posedge clk); while (!req_ch.ready);
        load_model_apply(ev);
    endtask

    // Drop valid, let every expected report drain, then cover a trailing frame RMW
    task automatic wait_quiet();
        req_ch.valid <= 1'b0;
        while (pending_loads.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Register write; caller makes sure the block is idle
    task automatic write_rate(input logic [CFG_IDX_W-1:0] idx,
                              input logic [RATE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx < NUM_REGS)
            rate_reg[idx] = value;
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Report receiver: per-item stall draw, plus a long hold-off on request
    // ---------------------------------------------------------------------
    initial
    begin
        int idle;
        load_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                load_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            idle = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            if (idle > 0)
            begin
                load_ch.ready <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            load_ch.ready <= 1'b1;
            do @(posedge clk); while (!load_ch.valid);
        end
    end

    // ---------------------------------------------------------------------
    // Report checker: every accepted report against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : check_reports
        load_report_t got;
        load_report_t want;
        if (rst_n && load_ch.valid && load_ch.ready)
        begin
            reports_seen++;
            got = {load_ch.load_bus, load_ch.load_percent, load_ch.last_of_tick};
            if (pending_loads.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("t=%0t unexpected report: bus %0d load %0d last %0b",
                             $realtime, got.bus, got.pct, got.last);
            end
            else
            begin
                want = pending_loads.pop_front();
                if (got.bus !== want.bus || got.pct !== want.pct || got.last !== want.last)
                begin
                    faults++;
                    if (faults <= 10)
                    begin
                        $write("t=%0t report mismatch: exp bus %0d load %0d last %0b, ",
                               $realtime, want.bus, want.pct, want.last);
                        $display("got bus %0d load %0d last %0b",
                                 got.bus, got.pct, got.last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Tick on a silent bus set, then a lone short frame at the reset rate:
    // its sample rounds to zero, so the smoothed load is forced to 1.
    task automatic test_idle_tick();
        send_event(mk_tick());
        send_event(mk_frame(0, 8, 1'b0));
        send_event(mk_tick());
    endtask

    // Shortest and longest frames, both ID kinds, every absent bus index
    task automatic test_frame_extremes();
        send_event(mk_frame(0, 0, 1'b0));
        send_event(mk_frame(1, LEN_CAN_FD, 1'b1));
        send_event(mk_frame(2, LEN_FULL, 1'b1));
        send_event(mk_frame(3, LEN_FULL, 1'b0));
        send_event(mk_frame(BUS_ABSENT_LO, LEN_FULL, 1'b1));
        send_event(mk_frame(BUS_ABSENT_HI, 0, 1'b0));
        send_event(mk_frame(5, LEN_CAN_FD, 1'b0));
        send_event(mk_frame(6, 1, 1'b1));
        send_event(mk_frame(3, LEN_CAN_FD, 1'b1));
        send_event(mk_tick());
    endtask

    // Zero and sub-4 rates fall back to the default budget; rate 4 gives a
    // budget of one bit and saturates the sample; all-ones rate is the top.
    // Writes to absent registers must leave the real ones alone.
    task automatic test_rate_extremes();
        wait_quiet();
        write_rate(REG_RATE_BUS0, '0);
        write_rate(REG_RATE_BUS1, 3);
        write_rate(REG_RATE_BUS2, 4);
        write_rate(REG_RATE_BUS3, RATE_FULL);
        write_rate(REG_NONE_FIRST, 7);
        write_rate(REG_NONE_LAST, 5);
        send_event(mk_frame(0, LEN_CAN_FD, 1'b1));
        send_event(mk_frame(1, LEN_FULL, 1'b1));
        send_event(mk_frame(2, LEN_CAN_FD, 1'b0));
        send_event(mk_frame(3, LEN_FULL, 1'b1));
        send_event(mk_tick());
        send_event(mk_frame(2, 0, 1'b0));
        send_event(mk_tick());
        // no traffic: saturated load decays without the forced floor
        send_event(mk_tick());
        wait_quiet();
        write_rate(REG_RATE_BUS1, 1000000);
        write_rate(REG_RATE_BUS2, 7);
    endtask

    // Receiver holds off while items keep coming, so the block backs up and
    // stalls its input; afterwards the sender waits for a full drain.
    task automatic test_backpressure();
        wait_quiet();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold    = HOLD_CYCLES;
        send_event(mk_tick());
        send_event(mk_frame(0, 12, 1'b0));
        send_event(mk_frame(2, 48, 1'b1));
        send_event(mk_tick());
        send_event(mk_frame(1, 3, 1'b1));
        send_event(mk_frame(3, 64, 1'b0));
        send_event(mk_tick());
        wait_quiet();
    endtask

    // Phases of random traffic, each with fresh rates and its own idling mix;
    // the first phase runs with no idling on either side.
    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_quiet();
            tx_idle_en = (phase != 0) && (phase != 3);
            rx_idle_en = (phase != 0) && (phase != 2);
            for (int b = 0; b < NUM_REGS; b++)
                write_rate(REG_RATE_BUS0 + CFG_IDX_W'(b), rand_rate());
            if (phase == 1)
                write_rate(CFG_IDX_W'($urandom_range(REG_NONE_FIRST, REG_NONE_LAST)),
                           rand_rate());
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_event(rand_event(18));
            send_event(mk_tick());
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        faults        = 0;
        frames_sent   = 0;
        frames_absent = 0;
        ticks_sent    = 0;
        reports_seen  = 0;
        cfg_writes    = 0;
        rx_hold       = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        load_model_reset();

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_FRAME;
        req_ch.bus_index    <= '0;
        req_ch.frame_length <= '0;
        req_ch.extended_id  <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_tick();
        test_frame_extremes();
        test_rate_extremes();
        test_backpressure();
        test_random_traffic();

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d frames (%0d on absent buses) and %0d ticks, %0d load reports",
                 frames_sent, frames_absent, ticks_sent, reports_seen);
        $display("%0d rate writes across fallback, unit-budget and full-scale rates, %0d faults",
                 cfg_writes, faults);
        if (faults == 0 && pending_loads.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
